/* sv/b2da_pkg.sv */
// Shared constants and types for the binary to decimal ASCII converter.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W        = 64;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 6;
    localparam int MAX_DIGITS_DEF = 20;

    // Shift-and-add-3 conversion, four binary bits consumed per cycle
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(CONV_STEPS);

    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_NINE   = 6'd57;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

    typedef enum logic [1:0]
    {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

endpackage

`default_nettype wire

/* sv/b2da_front.sv */
// Front end: accepts a 64-bit value and converts it to packed decimal digits.
// Depends on b2da_pkg.
`default_nettype none

module b2da_front
#(
    parameter int  MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1),
    localparam int BCD_W      = MAX_DIGITS * b2da_pkg::DIGIT_W
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
    output logic                               q_valid,
    input  wire logic                          q_stall,
    output logic [BCD_W-1:0]                   q_digits,
    output logic [CNT_W-1:0]                   q_count
);

    b2da_pkg::front_state_t             state_reg, state_next;
    logic [b2da_pkg::VALUE_W-1:0]       bin_reg, bin_next;
    logic [BCD_W-1:0]                   bcd_reg, bcd_next;
    logic [b2da_pkg::STEP_W-1:0]        step_reg, step_next;

    logic [b2da_pkg::VALUE_W-1:0]       dab_bin;
    logic [BCD_W-1:0]                   dab_bcd;
    logic [CNT_W-1:0]                   digit_cnt;
    logic                               bcd_ok;

    // Four shift-and-add-3 steps per cycle
    always_comb
    begin
        logic [b2da_pkg::VALUE_W-1:0] b;
        logic [BCD_W-1:0]             d;
        b = bin_reg;
        d = bcd_reg;
        for (int s = 0; s < b2da_pkg::BITS_PER_STEP; s++)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                if (d[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DABBLE_LIMIT)
                begin
                    d[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                        d[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADJ;
                end
            end
            d = {d[BCD_W-2:0], b[b2da_pkg::VALUE_W-1]};
            b = {b[b2da_pkg::VALUE_W-2:0], 1'b0};
        end
        dab_bin = b;
        dab_bcd = d;
    end

    // Significant digit count: highest nonzero digit, at least one
    always_comb
    begin
        digit_cnt = CNT_W'(1);
        bcd_ok    = 1'b1;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] != '0)
            begin
                digit_cnt = CNT_W'(i + 1);
            end
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] > b2da_pkg::DIGIT_MAX)
            begin
                bcd_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        in_stall   = (state_reg != b2da_pkg::FRONT_IDLE);
        q_valid    = (state_reg == b2da_pkg::FRONT_PUSH);
        q_digits   = bcd_reg;
        q_count    = digit_cnt;

        unique case (state_reg)
            b2da_pkg::FRONT_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next   = value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = b2da_pkg::FRONT_CONV;
                end
            end
            b2da_pkg::FRONT_CONV:
            begin
                bin_next  = dab_bin;
                bcd_next  = dab_bcd;
                step_next = step_reg + 1'b1;
                if (step_reg == b2da_pkg::STEP_W'(b2da_pkg::CONV_STEPS - 1))
                begin
                    state_next = b2da_pkg::FRONT_PUSH;
                end
            end
            b2da_pkg::FRONT_PUSH:
            begin
                if (!q_stall)
                begin
                    state_next = b2da_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2da_pkg::FRONT_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Every digit handed to the queue is a proper decimal digit
    a_front_bcd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == b2da_pkg::FRONT_PUSH |-> bcd_ok)
        else $error("front: non-decimal digit pushed");

    // Conversion always completes all steps before the push
    a_front_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == b2da_pkg::FRONT_PUSH) |->
            $past(step_reg) == b2da_pkg::STEP_W'(b2da_pkg::CONV_STEPS - 1))
        else $error("front: push before conversion finished");

endmodule

`default_nettype wire

/* sv/b2da_queue.sv */
// Small FIFO between the converting front end and the digit emitter.
// Depends on b2da_pkg for its default depth.
`default_nettype none

module b2da_queue
#(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = b2da_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [WIDTH-1:0]  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WIDTH-1:0]       out_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    always_comb
    begin
        in_stall  = (count_reg == CNT_W'(DEPTH));
        out_valid = (count_reg != '0);
        out_data  = mem_reg[rd_ptr_reg];
        push      = in_valid && !in_stall;
        pop       = out_valid && !out_stall;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Occupancy never exceeds the depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue: occupancy overflow");

endmodule

`default_nettype wire

/* sv/b2da_back.sv */
// Back end: takes converted digits from the queue and emits ASCII characters,
// most significant first. Depends on b2da_pkg.
`default_nettype none

module b2da_back
#(
    parameter int  MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1),
    localparam int IDX_W      = $clog2(MAX_DIGITS),
    localparam int BCD_W      = MAX_DIGITS * b2da_pkg::DIGIT_W
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [BCD_W-1:0]              in_digits,
    input  wire logic [CNT_W-1:0]              in_count,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit
);

    logic                           busy_reg, busy_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [BCD_W-1:0]               digits_reg, digits_next;
    logic                           out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                           last_reg, last_next;

    logic                           slot_free;
    logic [CNT_W-1:0]               cnt_m1;
    logic [b2da_pkg::DIGIT_W-1:0]   sel_digit;

    always_comb
    begin
        in_stall   = busy_reg;
        out_valid  = out_valid_reg;
        digit_char = char_reg;
        last_digit = last_reg;

        slot_free = !out_valid_reg || !out_stall;
        cnt_m1    = in_count - 1'b1;
        sel_digit = digits_reg[idx_reg*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        // Drop the beat once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next   = 1'b1;
                idx_next    = cnt_m1[IDX_W-1:0];
                digits_next = in_digits;
            end
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b1;
            char_next      = b2da_pkg::ASCII_ZERO +
                             {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, sel_digit};
            last_next      = (idx_reg == '0);
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    // With no value in progress, a pending beat must be the closing digit
    a_back_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !busy_reg |-> last_reg)
        else $error("back: idle with a non-final digit pending");

    // Emitted characters are decimal digits
    a_back_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg >= b2da_pkg::ASCII_ZERO) &&
                          (char_reg <= b2da_pkg::ASCII_NINE))
        else $error("back: character outside '0'..'9'");

endmodule

`default_nettype wire

/* sv/binary_to_decimal_ascii_core.sv */
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_queue and b2da_back.
//
// Usage:
//   Input channel (in_valid / in_stall / value): one beat carries a 64-bit
//   unsigned value. Output channel (out_valid / out_stall / digit_char /
//   last_digit): one beat per decimal digit, most significant first, as
//   ASCII '0'..'9'; last_digit marks the least significant digit. Zero
//   gives the single beat '0'. No leading zeros are sent.
//
// Timing:
//   The front end converts with a shift-and-add-3 unit that takes four
//   binary bits per cycle. It accepts a value, converts it and pushes the
//   result, and takes no new value until that push is done. A two-entry
//   queue decouples it from the emitter, which loads each value and then
//   sends one digit per cycle while the receiver does not stall.
//
// Reset clears all control state; the block is then empty and ready.
// A stalled receiver holds the current output beat; the emitter, then the
// queue, then the front end back up in turn, and in_stall rises.
`default_nettype none

module binary_to_decimal_ascii_core
#(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit
);

    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int BCD_W   = MAX_DIGITS * b2da_pkg::DIGIT_W;
    localparam int ENTRY_W = BCD_W + CNT_W;

    // Front end to queue
    logic               fq_valid;
    logic               fq_stall;
    logic [BCD_W-1:0]   fq_digits;
    logic [CNT_W-1:0]   fq_count;

    // Queue to back end
    logic               qb_valid;
    logic               qb_stall;
    logic [ENTRY_W-1:0] qb_entry;

    // Convert one value at a time into packed decimal digits
    b2da_front
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_valid  (fq_valid),
        .q_stall  (fq_stall),
        .q_digits (fq_digits),
        .q_count  (fq_count)
    );

    // Hold finished conversions while the emitter drains earlier ones
    b2da_queue
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (b2da_pkg::QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_stall  (fq_stall),
        .in_data   ({fq_count, fq_digits}),
        .out_valid (qb_valid),
        .out_stall (qb_stall),
        .out_data  (qb_entry)
    );

    // Emit digits, most significant first, through a registered output beat
    b2da_back
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (qb_valid),
        .in_stall   (qb_stall),
        .in_digits  (qb_entry[BCD_W-1:0]),
        .in_count   (qb_entry[ENTRY_W-1:BCD_W]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

`default_nettype wire

/* verif/tb_binary_to_decimal_ascii_core.sv */
// Self-checking testbench for binary_to_decimal_ascii_core: values in, decimal digit beats out.
// Depends on b2da_pkg and the core; a digit predictor or typed answer scores each beat.
`default_nettype none

module tb_binary_to_decimal_ascii_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS_MAX = b2da_pkg::MAX_DIGITS_DEF;
    localparam int DIR_N      = 14;
    localparam int RANDOM_N   = 96;
    localparam int IDLE_LIMIT = 5000;   // cycles with no beat on either side
    localparam int TAIL_WAIT  = 40;     // wait after the expected digits have all arrived

    typedef struct packed
    {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [b2da_pkg::VALUE_W-1:0]   value;
    logic                           out_valid;
    logic                           out_stall;
    logic [b2da_pkg::CHAR_W-1:0]    digit_char;
    logic                           last_digit;

    // Digits still owed by the core, oldest first.
    digit_beat_t          pending_digits[$];

    int                   mismatches;
    int                   values_sent;
    int                   digits_checked;
    int                   idle_cycles;
    bit                   quiet;          // no idling on either side while set
    bit                   length_seen [1:DIGITS_MAX];

    // Directed rows: a non-empty text is the answer typed in; empty means use the predictor.
    logic [b2da_pkg::VALUE_W-1:0]   dir_value [DIR_N];
    string                          dir_text  [DIR_N];

    binary_to_decimal_ascii_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [b2da_pkg::VALUE_W-1:0] power_of_ten(input int k);
        logic [b2da_pkg::VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // Divide by ten until nothing is left, then queue the remainders
    // most significant first. Zero still yields one digit.
    function automatic void predict_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
        logic [b2da_pkg::DIGIT_W-1:0] rems [DIGITS_MAX];
        logic [b2da_pkg::VALUE_W-1:0] rest;
        int                           n;
        digit_beat_t                  beat;
        rest = v;
        n    = 0;
        do
        begin
            rems[n] = b2da_pkg::DIGIT_W'(rest % 10);
            rest    = rest / 10;
            n++;
        end
        while (rest != 0 && n < DIGITS_MAX);
        for (int k = n - 1; k >= 0; k--)
        begin
            beat.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rems[k]);
            beat.last = (k == 0);
            pending_digits.push_back(beat);
        end
        length_seen[n] = 1'b1;
    endfunction

    // Random value: mostly a random bit length so every digit count shows up,
    // then neighbors of powers of ten (carry edges), then full-width noise.
    function automatic logic [b2da_pkg::VALUE_W-1:0] random_value();
        logic [b2da_pkg::VALUE_W-1:0] raw;
        logic [b2da_pkg::VALUE_W-1:0] p;
        int                           r;
        int                           bits;
        int                           k;
        raw = {$urandom(), $urandom()};
        r   = $urandom_range(0, 99);
        if (r < 60)
        begin
            bits = $urandom_range(1, b2da_pkg::VALUE_W);
            if (bits == b2da_pkg::VALUE_W)
                return raw;
            return raw & ((64'd1 << bits) - 1);
        end
        else if (r < 85)
        begin
            k = $urandom_range(0, DIGITS_MAX - 1);
            p = power_of_ten(k);
            case ($urandom_range(0, 2))
                0:       return p - 1;
                1:       return p;
                default: return p + 1;
            endcase
        end
        return raw;
    endfunction

    // Drive one value at a falling edge after an optional gap, hold it until
    // the core takes it, then log what it must answer.
    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v, input string text);
        int          gap;
        digit_beat_t beat;
        gap = quiet ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        // Beat taken at this edge.
        if (text.len() == 0)
            predict_digits(v);
        else
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                beat.ch   = b2da_pkg::CHAR_W'(text[i]);
                beat.last = (i == text.len() - 1);
                pending_digits.push_back(beat);
            end
            length_seen[text.len()] = 1'b1;
        end
        values_sent++;
    endtask

    // Receiver back-pressure: random stall bursts, none while quiet.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = quiet ? 0 : idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Score every digit beat against the oldest pending digit.
    always @(posedge clk)
    begin
        digit_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit beat: digit_char=%0d last_digit=%0b",
                       digit_char, last_digit);
                mismatches++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit_char !== want.ch)
                begin
                    $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
                    mismatches++;
                end
                if (last_digit !== want.last)
                begin
                    $error("last_digit: expected %0b, got %0b", want.last, last_digit);
                    mismatches++;
                end
                digits_checked++;
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d digits outstanding",
                     idle_cycles, pending_digits.size());
            $display("[binary_to_decimal_ascii_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int lengths;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        quiet          = 1'b1;
        mismatches     = 0;
        values_sent    = 0;
        digits_checked = 0;
        idle_cycles    = 0;
        foreach (length_seen[i])
            length_seen[i] = 1'b0;

        // Extremes, carry edges and the top bit get their answers spelled out;
        // the other bit patterns and the smaller carry edges go through the predictor.
        dir_value = '{
            64'd0,
            64'd1,
            64'd9,
            64'd10,
            64'd18446744073709551615,
            64'd10000000000000000000,
            64'd9999999999999999999,
            64'h8000_0000_0000_0000,
            64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA,
            64'd12345678901234567890,
            64'd4294967295,
            64'd999,
            64'd1000
        };
        dir_text = '{
            "0",
            "1",
            "9",
            "10",
            "18446744073709551615",
            "10000000000000000000",
            "9999999999999999999",
            "9223372036854775808",
            "", "", "", "", "", ""
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: first half back to back, then with random idling.
        for (int i = 0; i < DIR_N; i++)
        begin
            quiet = (i < DIR_N / 2);
            send_value(dir_value[i], dir_text[i]);
        end

        // Random part; switch idling on and off in stretches and drain the
        // core fully once midway with the input held off.
        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (i % 16 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_N / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_digits.size() != 0)
                    @(negedge clk);
            end
            send_value(random_value(), "");
        end
        @(negedge clk);
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (pending_digits.size() != 0)
        begin
            $error("%0d expected digits never arrived", pending_digits.size());
            mismatches++;
        end

        lengths = 0;
        foreach (length_seen[i])
            lengths += length_seen[i];
        $display("Converted %0d values and checked %0d digit beats under random stalls.",
                 values_sent, digits_checked);
        $display("Decimal lengths reached: %0d of %0d; mismatches: %0d.",
                 lengths, DIGITS_MAX, mismatches);

        if (mismatches == 0)
            $display("[binary_to_decimal_ascii_core] OK");
        else
            $display("[binary_to_decimal_ascii_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/b2da_pkg.sv
sv/b2da_front.sv
sv/b2da_queue.sv
sv/b2da_back.sv
sv/binary_to_decimal_ascii_core.sv
verif/tb_binary_to_decimal_ascii_core.sv
